/* hdl/ring_buffer_pattern_search_defines.svh */
// Assertion macros shared by the checker of the ring buffer pattern search.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef RING_BUFFER_PATTERN_SEARCH_DEFINES_SVH
`define RING_BUFFER_PATTERN_SEARCH_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RBPS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbps assertion failed");

// Next-cycle implication, checked out of reset.
`define RBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbps assertion failed");

`endif

/* hdl/rbps_pkg.sv */
// Package for the ring buffer pattern search: field widths, command codes,
// default depths and the control/status structs between controller and datapath.
`default_nettype none

package rbps_pkg;

    // Default store depths.
    localparam int SRC_DEPTH_DEF = 256;
    localparam int PAT_DEPTH_DEF = 16;

    // Fixed field widths.
    localparam int CMD_W  = 2;
    localparam int ADDR_W = 8;
    localparam int BYTE_W = 8;
    localparam int PLEN_W = 5;
    localparam int POS_W  = 8;
    localparam int SIZE_W = 9;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_WR_SRC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_PAT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // Source size after reset.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_src;
        logic wr_pat;
        logic start_search;
        logic adv_k;
        logic adv_start;
        logic set_result;
        logic res_found;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic size_zero;
        logic len_zero;
        logic byte_match;
        logic k_last;
        logic start_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* hdl/rbps_ctrl.sv */
// Controller state machine of the ring buffer pattern search.
// Depends on rbps_pkg for command codes and the control/status structs.
`default_nettype none

module rbps_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [rbps_pkg::CMD_W-1:0] cmd,
    output logic                       in_stall,
    input  rbps_pkg::dp_status_t       status,
    output rbps_pkg::ctrl_cmd_t        ctrl
);
    import rbps_pkg::*;

    // State codes.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_POST  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Input beats are taken only while idle.
    assign in_stall = (state_reg != ST_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        CMD_WR_SRC: ctrl.wr_src = 1'b1;
                        CMD_WR_PAT: ctrl.wr_pat = 1'b1;
                        CMD_SEARCH:
                        begin
                            ctrl.start_search = 1'b1;
                            state_next        = ST_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHECK:
            begin
                // An empty buffer never matches; an empty pattern matches at start 0.
                if (status.size_zero)
                begin
                    ctrl.set_result = 1'b1;
                    state_next      = ST_POST;
                end
                else if (status.len_zero)
                begin
                    ctrl.set_result = 1'b1;
                    ctrl.res_found  = 1'b1;
                    state_next      = ST_POST;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.byte_match)
                begin
                    if (status.k_last)
                    begin
                        ctrl.set_result = 1'b1;
                        ctrl.res_found  = 1'b1;
                        state_next      = ST_POST;
                    end
                    else
                    begin
                        ctrl.adv_k = 1'b1;
                        state_next = ST_RD;
                    end
                end
                else if (status.start_last)
                begin
                    ctrl.set_result = 1'b1;
                    state_next      = ST_POST;
                end
                else
                begin
                    ctrl.adv_start = 1'b1;
                    state_next     = ST_RD;
                end
            end
            ST_POST:
            begin
                // Hand the result to the output register once it is free.
                if (status.out_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/rbps_datapath.sv */
// Datapath of the ring buffer pattern search: source and pattern memories,
// search counters, size register and output register. Depends on rbps_pkg.
`default_nettype none

module rbps_datapath #(
    parameter int SRC_DEPTH = rbps_pkg::SRC_DEPTH_DEF,
    parameter int PAT_DEPTH = rbps_pkg::PAT_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [rbps_pkg::SIZE_W-1:0] source_size,
    input  logic [rbps_pkg::ADDR_W-1:0] addr,
    input  logic [rbps_pkg::BYTE_W-1:0] data_byte,
    input  logic [rbps_pkg::PLEN_W-1:0] pattern_len,
    input  rbps_pkg::ctrl_cmd_t         ctrl,
    output rbps_pkg::dp_status_t        status,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic                        found,
    output logic [rbps_pkg::POS_W-1:0]  position
);
    import rbps_pkg::*;

    localparam int SA_W = $clog2(SRC_DEPTH);
    localparam int PA_W = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
    localparam int CW   = ((SA_W > SIZE_W) ? SA_W : SIZE_W) + 1;
    localparam int KW   = (PA_W > PLEN_W) ? PA_W : PLEN_W;
    localparam int LCW  = KW + 2;
    localparam logic [CW-1:0]  SRC_DEPTH_C = CW'(SRC_DEPTH);
    localparam logic [CW-1:0]  PAT_DEPTH_C = CW'(PAT_DEPTH);
    localparam logic [LCW-1:0] PAT_LEN_MAX = LCW'(PAT_DEPTH);

    // Memories and their registered read data.
    logic [BYTE_W-1:0] src_mem [SRC_DEPTH];
    logic [BYTE_W-1:0] pat_mem [PAT_DEPTH];
    logic [BYTE_W-1:0] src_rd_reg;
    logic [BYTE_W-1:0] pat_rd_reg;

    // Registers.
    logic [SIZE_W-1:0] size_cfg_reg,  size_cfg_next;
    logic [SIZE_W-1:0] size_reg,      size_next;
    logic [PLEN_W-1:0] len_reg,       len_next;
    logic [SA_W-1:0]   start_reg,     start_next;
    logic [SA_W-1:0]   pos_reg,       pos_next;
    logic [KW-1:0]     k_reg,         k_next;
    logic              res_found_reg, res_found_next;
    logic [POS_W-1:0]  res_pos_reg,   res_pos_next;
    logic              out_valid_reg, out_valid_next;
    logic              found_reg,     found_next;
    logic [POS_W-1:0]  position_reg,  position_next;

    // Working values.
    logic [CW-1:0]     addr_ext;
    logic              src_wr_ok;
    logic              pat_wr_ok;
    logic [CW-1:0]     cfg_ext;
    logic [SIZE_W-1:0] size_clamp;
    logic [LCW-1:0]    plen_ext;
    logic [PLEN_W-1:0] len_clamp;
    logic [CW-1:0]     size_ext;
    logic [CW-1:0]     start_ext;
    logic [CW-1:0]     start_inc;
    logic [CW-1:0]     pos_inc;
    logic [SA_W-1:0]   pos_wrap;
    logic [KW:0]       k_inc;

    // Address range checks and clamping of size and length.
    always_comb
    begin
        addr_ext   = CW'(addr);
        src_wr_ok  = (addr_ext < SRC_DEPTH_C);
        pat_wr_ok  = (addr_ext < PAT_DEPTH_C);
        cfg_ext    = CW'(size_cfg_reg);
        size_clamp = (cfg_ext > SRC_DEPTH_C) ? SIZE_W'(SRC_DEPTH_C) : size_cfg_reg;
        plen_ext   = LCW'(pattern_len);
        len_clamp  = (plen_ext > PAT_LEN_MAX) ? PLEN_W'(PAT_LEN_MAX) : pattern_len;
    end

    // Counter arithmetic; the source index wraps at the clamped size.
    always_comb
    begin
        size_ext  = CW'(size_reg);
        start_ext = CW'(start_reg);
        start_inc = start_ext + CW'(1);
        pos_inc   = CW'(pos_reg) + CW'(1);
        pos_wrap  = (pos_inc >= size_ext) ? '0 : pos_inc[SA_W-1:0];
        k_inc     = (KW + 1)'(k_reg) + (KW + 1)'(1);
    end

    // Status toward the controller.
    always_comb
    begin
        status.size_zero  = (size_reg == '0);
        status.len_zero   = (len_reg == '0);
        status.byte_match = (src_rd_reg == pat_rd_reg);
        status.k_last     = (k_inc == (KW + 1)'(len_reg));
        status.start_last = (start_inc >= size_ext);
        status.out_free   = !out_valid_reg || !out_stall;
    end

    // Next values of the search registers.
    always_comb
    begin
        size_cfg_next  = cfg_valid ? source_size : size_cfg_reg;
        size_next      = size_reg;
        len_next       = len_reg;
        start_next     = start_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        if (ctrl.start_search)
        begin
            size_next  = size_clamp;
            len_next   = len_clamp;
            start_next = '0;
            pos_next   = '0;
            k_next     = '0;
        end
        if (ctrl.adv_k)
        begin
            k_next   = k_inc[KW-1:0];
            pos_next = pos_wrap;
        end
        if (ctrl.adv_start)
        begin
            // The next start is below the size, so it needs no wrap.
            start_next = start_inc[SA_W-1:0];
            pos_next   = start_inc[SA_W-1:0];
            k_next     = '0;
        end
        if (ctrl.set_result)
        begin
            res_found_next = ctrl.res_found;
            res_pos_next   = ctrl.res_found ? start_ext[POS_W-1:0] : '0;
        end
    end

    // Next values of the output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        position_next  = position_reg;
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
            found_next     = res_found_reg;
            position_next  = res_pos_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg  <= SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_cfg_reg  <= size_cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        size_reg      <= size_next;
        len_reg       <= len_next;
        start_reg     <= start_next;
        pos_reg       <= pos_next;
        k_reg         <= k_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        found_reg     <= found_next;
        position_reg  <= position_next;
    end

    // Source memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_src && src_wr_ok)
        begin
            src_mem[addr_ext[SA_W-1:0]] <= data_byte;
        end
        src_rd_reg <= src_mem[pos_reg];
    end

    // Pattern memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_pat && pat_wr_ok)
        begin
            pat_mem[addr_ext[PA_W-1:0]] <= data_byte;
        end
        pat_rd_reg <= pat_mem[k_reg[PA_W-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

endmodule

`default_nettype wire

/* hdl/ring_buffer_pattern_search.sv */
// Ring buffer pattern search, top level; joins rbps_ctrl and rbps_datapath and
// depends on rbps_pkg. Write beats (source byte or pattern byte) are taken
// without stalling the input. A search beat holds the input stalled while it
// makes C byte compares, where C is at most min(source_size, SRC_DEPTH) times
// min(pattern_len, PAT_DEPTH); each compare takes a memory read state and a
// compare state on the single registered read port of each store. The stall
// grows by every cycle that the previous result still waits in the output
// register once the walk is done. The result sits in an output register, so
// a write beat may be taken while it waits.
// The source_size register is taken on any cfg beat and applies to the next search.
`default_nettype none

module ring_buffer_pattern_search #(
    parameter int SRC_DEPTH = rbps_pkg::SRC_DEPTH_DEF,
    parameter int PAT_DEPTH = rbps_pkg::PAT_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rbps_pkg::SIZE_W-1:0] source_size,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rbps_pkg::CMD_W-1:0]  cmd,
    input  logic [rbps_pkg::ADDR_W-1:0] addr,
    input  logic [rbps_pkg::BYTE_W-1:0] data_byte,
    input  logic [rbps_pkg::PLEN_W-1:0] pattern_len,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic [rbps_pkg::POS_W-1:0]  position
);
    import rbps_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    // The size register accepts a write in any cycle.
    assign cfg_ready = 1'b1;

    // Controller.
    rbps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_stall (in_stall),
        .status   (status),
        .ctrl     (ctrl)
    );

    // Datapath.
    rbps_datapath #(
        .SRC_DEPTH (SRC_DEPTH),
        .PAT_DEPTH (PAT_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .source_size (source_size),
        .addr        (addr),
        .data_byte   (data_byte),
        .pattern_len (pattern_len),
        .ctrl        (ctrl),
        .status      (status),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .found       (found),
        .position    (position)
    );

endmodule

`default_nettype wire

/* hdl/rbps_checker.sv */
// Port-level checker for the ring buffer pattern search, bound to the top level.
// Depends on rbps_pkg and the macros in ring_buffer_pattern_search_defines.svh.
`default_nettype none
`include "ring_buffer_pattern_search_defines.svh"

module rbps_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [rbps_pkg::CMD_W-1:0]  cmd,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        found,
    input logic [rbps_pkg::POS_W-1:0]  position
);
    import rbps_pkg::*;

    // A stalled result beat stays offered.
    `RBPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // A not-found result always reports position zero.
    `RBPS_ASSERT_IMPL(a_notfound_pos, out_valid && !found, position == '0)

    // An accepted search beat always occupies the block for its walk.
    `RBPS_ASSERT_NEXT(a_search_busy, in_valid && !in_stall && cmd == CMD_SEARCH, in_stall)

    // A write beat with no result pending never produces a result.
    `RBPS_ASSERT_NEXT(a_write_silent,
        in_valid && !in_stall && cmd != CMD_SEARCH && !out_valid, !out_valid)

endmodule

bind ring_buffer_pattern_search rbps_checker u_rbps_checker (.*);

`default_nettype wire
